>>> hw/rtl/bbp_pkg.sv
// Package for the bimodal two-bit branch predictor.
// Holds table geometry, payload structs and the stats update struct.
// No dependencies.
`default_nettype none

package bbp_pkg;

  // Table depth; a power of two, so the index is a plain bit slice of the address.
  localparam int unsigned ENTRIES = 128;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CTR_W   = 2;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAT_W  = 32;

  // Byte address to word address
  localparam int unsigned ADDR_LSB = 2;

  localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } bbp_in_t;

  typedef struct packed {
    logic              predicted_taken;
    logic              was_correct;
    logic [STAT_W-1:0] total_branches;
    logic [STAT_W-1:0] taken_total;
    logic [STAT_W-1:0] taken_correct;
    logic [STAT_W-1:0] not_taken_total;
    logic [STAT_W-1:0] not_taken_correct;
  } bbp_out_t;

  // One resolved branch as seen by the statistics block
  typedef struct packed {
    logic valid;
    logic taken;
    logic hit;
  } bbp_upd_t;

  typedef struct packed {
    logic [STAT_W-1:0] total_branches;
    logic [STAT_W-1:0] taken_total;
    logic [STAT_W-1:0] taken_correct;
    logic [STAT_W-1:0] not_taken_total;
    logic [STAT_W-1:0] not_taken_correct;
  } bbp_stats_t;

endpackage

`default_nettype wire

>>> hw/rtl/two_bit_branch_predictor_core.sv
// Top level of the bimodal two-bit branch predictor.
// Depends on bbp_pkg, bbp_ram and bbp_stats.
`default_nettype none

// Usage:
//   Input: drive req_i with a resolved branch and raise start; the branch is
//   transferred at a rising edge where start is high and busy is low.
//   Output: done_o is high for exactly one cycle with res_o holding the
//   prediction, the hit flag and the five statistics after this branch.
//   The receiver cannot stall; every result must be taken on its strobe.
//   A transferred branch passes the update stage and the result registers
//   before done_o rises. Throughput: one branch per cycle while busy is low.
//   The counter table lives in one RAM with a registered read port:
//   the read is issued on the transfer edge, the modify and write-back take
//   the following cycle. A back-to-back branch to the same entry takes the
//   updated counter from a forwarding register instead of the RAM.
//   Reset: the statistics clear at once; the table is cleared by a pass over
//   all ENTRIES (128) entries right after reset, during which busy is high.

module two_bit_branch_predictor_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire bbp_pkg::bbp_in_t  req_i,
  output logic                   done_o,
  output bbp_pkg::bbp_out_t      res_o
);

  import bbp_pkg::*;

  // Reset clearing pass
  logic             clearing_q;
  logic [IDX_W-1:0] clr_idx_q;

  // Update stage
  logic             s1_valid_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_taken_q;
  logic             fwd_q;
  logic [CTR_W-1:0] fwd_ctr_q;

  // Result registers
  logic             done_q;
  logic             pred_q;
  logic             hit_q;

  logic             accept;
  logic [IDX_W-1:0] idx_in;
  logic [CTR_W-1:0] ram_rdata;
  logic [CTR_W-1:0] ctr_cur;
  logic [CTR_W-1:0] ctr_new;
  logic             pred;
  logic             hit;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CTR_W-1:0] ram_wdata;
  logic             fwd_d;
  bbp_upd_t         upd;
  bbp_stats_t       stats;

  assign accept = start & ~clearing_q;
  assign busy   = clearing_q;
  assign idx_in = req_i.branch_address[ADDR_LSB +: IDX_W];

  assign ctr_cur = fwd_q ? fwd_ctr_q : ram_rdata;
  assign pred    = ctr_cur[CTR_W-1];
  assign hit     = (pred == s1_taken_q);

  always_comb begin
    ctr_new = ctr_cur;
    if (s1_taken_q) begin
      if (ctr_cur != CTR_MAX) begin
        ctr_new = ctr_cur + CTR_W'(1);
      end
    end else begin
      if (ctr_cur != CTR_MIN) begin
        ctr_new = ctr_cur - CTR_W'(1);
      end
    end
  end

  assign ram_we    = clearing_q | s1_valid_q;
  assign ram_waddr = clearing_q ? clr_idx_q : s1_idx_q;
  assign ram_wdata = clearing_q ? CTR_MIN : ctr_new;

  // RAM read and write to the same entry collide on one edge; forward instead
  assign fwd_d = accept & s1_valid_q & (idx_in == s1_idx_q);

  bbp_ram #(
    .WIDTH(CTR_W),
    .DEPTH(ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(idx_in),
    .rdata_o(ram_rdata)
  );

  assign upd.valid = s1_valid_q;
  assign upd.taken = s1_taken_q;
  assign upd.hit   = hit;

  bbp_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .stats_o(stats)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
        if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      s1_valid_q <= accept;
      fwd_q      <= fwd_d;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q   <= idx_in;
      s1_taken_q <= req_i.taken;
    end
    fwd_ctr_q <= ctr_new;
    if (s1_valid_q) begin
      pred_q <= pred;
      hit_q  <= hit;
    end
  end

  assign done_o                  = done_q;
  assign res_o.predicted_taken   = pred_q;
  assign res_o.was_correct       = hit_q;
  assign res_o.total_branches    = stats.total_branches;
  assign res_o.taken_total       = stats.taken_total;
  assign res_o.taken_correct     = stats.taken_correct;
  assign res_o.not_taken_total   = stats.not_taken_total;
  assign res_o.not_taken_correct = stats.not_taken_correct;

endmodule

`default_nettype wire

>>> hw/rtl/bbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bbp_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bbp_stats.sv
// Five saturating statistics counters of the branch predictor.
// Depends on bbp_pkg.
`default_nettype none

module bbp_stats (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire bbp_pkg::bbp_upd_t   upd_i,
  output bbp_pkg::bbp_stats_t      stats_o
);

  import bbp_pkg::*;

  bbp_stats_t cnt_q, cnt_d;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    logic [STAT_W-1:0] r;
    r = (v == {STAT_W{1'b1}}) ? v : v + STAT_W'(1);
    return r;
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (upd_i.valid) begin
      cnt_d.total_branches = sat_inc(cnt_q.total_branches);
      if (upd_i.taken) begin
        cnt_d.taken_total = sat_inc(cnt_q.taken_total);
        if (upd_i.hit) begin
          cnt_d.taken_correct = sat_inc(cnt_q.taken_correct);
        end
      end else begin
        cnt_d.not_taken_total = sat_inc(cnt_q.not_taken_total);
        if (upd_i.hit) begin
          cnt_d.not_taken_correct = sat_inc(cnt_q.not_taken_correct);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign stats_o = cnt_q;

endmodule

`default_nettype wire
